@@ hdl/apt_pkg.sv @@
// ----------------------------------------------------------------------------
// apt_pkg: shared types and constants for the aging priority task picker
// Slot, count and weight widths, op codes, sequencer states and the
// structs that pass between the sequencer, the age queue and the weight unit.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int SLOTS        = 16;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int HARTS        = 2;
  localparam int HART_W       = 1;
  localparam int PRIO_W       = 4;
  localparam int TPS_W        = 24;
  localparam int TIME_W       = 32;
  localparam int OP_W         = 2;
  localparam int WEIGHT_SHIFT = 6;
  localparam int PROD_W       = PRIO_W + TPS_W;
  localparam int SCALED_W     = PROD_W - WEIGHT_SHIFT;

  localparam logic [TPS_W-1:0] TPS_RESET = 24'd10000000;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PICK   = 2'd2,
    OP_NOP    = 2'd3
  } apt_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } apt_state_t;

  // One age-queue entry handed to the weight unit
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] slot;
    logic              eligible;
    logic              match;
  } apt_issue_t;

  // Running result of a scan
  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] best_w;
    logic [SLOT_W-1:0] best_pos;
    logic [SLOT_W-1:0] best_slot;
    logic              match_hit;
    logic [SLOT_W-1:0] match_pos;
  } apt_scan_res_t;

  // Age queue update for one cycle
  typedef struct packed {
    logic              drop_en;
    logic [SLOT_W-1:0] drop_pos;
    logic              push_en;
    logic [SLOT_W-1:0] push_slot;
  } apt_q_ctrl_t;

endpackage

@@ hdl/apt_age_queue.sv @@
// ----------------------------------------------------------------------------
// apt_age_queue: insertion-age order of ready slots
// Position 0 holds the oldest slot. A drop closes the gap, a push appends
// the newest slot; both may happen in the same cycle.
// ----------------------------------------------------------------------------
module apt_age_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  apt_pkg::apt_q_ctrl_t       ctrl,
  input  logic [apt_pkg::SLOT_W-1:0] rd_idx,
  output logic [apt_pkg::SLOT_W-1:0] rd_slot,
  output logic [apt_pkg::CNT_W-1:0]  count
);

  logic [apt_pkg::SLOT_W-1:0] q_r   [apt_pkg::SLOTS];
  logic [apt_pkg::SLOT_W-1:0] q_nxt [apt_pkg::SLOTS];
  logic [apt_pkg::CNT_W-1:0]  cnt_r;
  logic [apt_pkg::CNT_W-1:0]  cnt_nxt;
  logic [apt_pkg::CNT_W-1:0]  cnt_drop;

  assign rd_slot = q_r[rd_idx];
  assign count   = cnt_r;

  // Close the gap at the dropped position, then append the pushed slot
  always_comb begin
    q_nxt    = q_r;
    cnt_drop = cnt_r;
    if (ctrl.drop_en && ({1'b0, ctrl.drop_pos} < cnt_r)) begin
      for (int k = 0; k < apt_pkg::SLOTS - 1; k++) begin
        if (apt_pkg::SLOT_W'(k) >= ctrl.drop_pos) begin
          q_nxt[k] = q_r[k+1];
        end
      end
      cnt_drop = cnt_r - 1'b1;
    end
    cnt_nxt = cnt_drop;
    if (ctrl.push_en && (cnt_drop < apt_pkg::CNT_W'(apt_pkg::SLOTS))) begin
      q_nxt[cnt_drop[apt_pkg::SLOT_W-1:0]] = ctrl.push_slot;
      cnt_nxt = cnt_drop + 1'b1;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Queue entries
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

@@ hdl/apt_weight_unit.sv @@
// ----------------------------------------------------------------------------
// apt_weight_unit: shared weight and compare unit
// Stage one scales the priority and takes the age of the stamp; stage two
// forms the weight and keeps the best entry and the slot match of a scan.
// ----------------------------------------------------------------------------
module apt_weight_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  apt_pkg::apt_issue_t        issue,
  input  logic [apt_pkg::PRIO_W-1:0] prio,
  input  logic [apt_pkg::TIME_W-1:0] stamp,
  input  logic [apt_pkg::TPS_W-1:0]  tps,
  input  logic [apt_pkg::TIME_W-1:0] now,
  output apt_pkg::apt_scan_res_t     res
);

  logic [apt_pkg::PROD_W-1:0]   prod;
  logic                         s1_valid_r;
  logic [apt_pkg::SLOT_W-1:0]   s1_pos_r;
  logic [apt_pkg::SLOT_W-1:0]   s1_slot_r;
  logic                         s1_elig_r;
  logic                         s1_match_r;
  logic [apt_pkg::SCALED_W-1:0] s1_scaled_r;
  logic [apt_pkg::TIME_W-1:0]   s1_diff_r;
  logic [apt_pkg::TIME_W-1:0]   weight;
  logic                         take_best;
  logic                         hit_r;
  logic                         match_hit_r;
  logic [apt_pkg::TIME_W-1:0]   best_w_r;
  logic [apt_pkg::SLOT_W-1:0]   best_pos_r;
  logic [apt_pkg::SLOT_W-1:0]   best_slot_r;
  logic [apt_pkg::SLOT_W-1:0]   match_pos_r;

  assign prod = apt_pkg::PROD_W'(prio) * apt_pkg::PROD_W'(tps);

  // Stage one valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue.valid;
    end
  end

  // Stage one payload: scaled priority and stamp age
  always_ff @(posedge clk) begin
    s1_pos_r    <= issue.pos;
    s1_slot_r   <= issue.slot;
    s1_elig_r   <= issue.eligible;
    s1_match_r  <= issue.match;
    s1_scaled_r <= prod[apt_pkg::PROD_W-1:apt_pkg::WEIGHT_SHIFT];
    s1_diff_r   <= now - stamp;
  end

  assign weight    = apt_pkg::TIME_W'(s1_scaled_r) + s1_diff_r;
  assign take_best = s1_valid_r && s1_elig_r && (weight > best_w_r);

  // Stage two: keep the strictly larger weight, so the older entry wins a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      match_hit_r <= 1'b0;
      best_w_r    <= '0;
    end else if (clear) begin
      hit_r       <= 1'b0;
      match_hit_r <= 1'b0;
      best_w_r    <= '0;
    end else if (s1_valid_r) begin
      if (take_best) begin
        hit_r    <= 1'b1;
        best_w_r <= weight;
      end
      if (s1_match_r) begin
        match_hit_r <= 1'b1;
      end
    end
  end

  // Positions of the best entry and of the matching slot
  always_ff @(posedge clk) begin
    if (take_best) begin
      best_pos_r  <= s1_pos_r;
      best_slot_r <= s1_slot_r;
    end
    if (s1_valid_r && s1_match_r) begin
      match_pos_r <= s1_pos_r;
    end
  end

  // Collect the scan result
  always_comb begin
    res.hit       = hit_r;
    res.best_w    = best_w_r;
    res.best_pos  = best_pos_r;
    res.best_slot = best_slot_r;
    res.match_hit = match_hit_r;
    res.match_pos = match_pos_r;
  end

endmodule

@@ hdl/aging_priority_task_picker_top.sv @@
// ----------------------------------------------------------------------------
// aging_priority_task_picker_top: ready set of task slots with aging pick
// Insert, remove and pick on up to sixteen task slots, with a weight of
// scaled priority plus waiting time and oldest-first tie breaking.
// ----------------------------------------------------------------------------
// Every op walks the age queue one entry per cycle through the single weight
// unit (a 4x24 multiply, then a 32-bit add and compare), then sees the end of
// the queue, drains that unit and updates the ready set. Insert and remove use
// the same walk to find the slot's age position. The input is ready only while
// no item is in work; a finished result sits in the output register and the
// next item's result waits for it to be taken. Nothing needs a clearing pass
// after reset, and ticks_per_second comes up at 10000000.
// ----------------------------------------------------------------------------
module aging_priority_task_picker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_slot,
  input  logic [3:0]  in_prio,
  input  logic [1:0]  in_eligible_harts,
  input  logic        in_hart,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [3:0]  out_winner,
  output logic [31:0] out_best_weight
);

  apt_pkg::apt_state_t          state_r;
  apt_pkg::apt_state_t          state_nxt;
  logic [apt_pkg::TPS_W-1:0]    tps_r;
  logic [apt_pkg::SLOTS-1:0]    ready_r;
  logic [apt_pkg::PRIO_W-1:0]   slot_prio_r  [apt_pkg::SLOTS];
  logic [1:0]                   slot_mask_r  [apt_pkg::SLOTS];
  logic [apt_pkg::TIME_W-1:0]   slot_stamp_r [apt_pkg::SLOTS];

  apt_pkg::apt_op_t             op_r;
  logic [apt_pkg::SLOT_W-1:0]   slot_r;
  logic [apt_pkg::PRIO_W-1:0]   prio_r;
  logic [1:0]                   mask_r;
  logic [apt_pkg::HART_W-1:0]   hart_r;
  logic [apt_pkg::TIME_W-1:0]   now_r;
  logic [apt_pkg::CNT_W-1:0]    idx_r;

  logic                         out_valid_r;
  logic                         out_found_r;
  logic [apt_pkg::SLOT_W-1:0]   out_winner_r;
  logic [apt_pkg::TIME_W-1:0]   out_weight_r;

  logic                         accept;
  logic                         scan_more;
  logic                         upd_go;
  logic                         slot_ready;
  logic [apt_pkg::SLOT_W-1:0]   rd_slot;
  logic [apt_pkg::CNT_W-1:0]    age_cnt;
  apt_pkg::apt_issue_t          issue;
  apt_pkg::apt_scan_res_t       res;
  apt_pkg::apt_q_ctrl_t         q_ctrl;

  assign accept     = in_valid && in_ready;
  assign scan_more  = (idx_r < age_cnt);
  assign slot_ready = ready_r[slot_r];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= apt_pkg::TPS_RESET;
    end else if (cfg_wr_en) begin
      tps_r <= cfg_wr_data;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apt_pkg::S_IDLE:   if (in_valid) state_nxt = apt_pkg::S_SCAN;
      apt_pkg::S_SCAN:   if (!scan_more) state_nxt = apt_pkg::S_DRAIN;
      apt_pkg::S_DRAIN:  state_nxt = apt_pkg::S_UPDATE;
      apt_pkg::S_UPDATE: if (!out_valid_r || out_ready) state_nxt = apt_pkg::S_IDLE;
      default:           state_nxt = apt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    upd_go   = 1'b0;
    unique case (state_r)
      apt_pkg::S_IDLE:   in_ready = 1'b1;
      apt_pkg::S_SCAN:   ;
      apt_pkg::S_DRAIN:  ;
      apt_pkg::S_UPDATE: upd_go = !out_valid_r || out_ready;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the item and step the scan index
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= apt_pkg::apt_op_t'(in_op);
      slot_r <= in_slot;
      prio_r <= in_prio;
      mask_r <= in_eligible_harts;
      hart_r <= in_hart;
      now_r  <= in_time_now;
      idx_r  <= '0;
    end else if ((state_r == apt_pkg::S_SCAN) && scan_more) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Feed one age-queue entry per cycle to the weight unit
  always_comb begin
    issue.valid    = (state_r == apt_pkg::S_SCAN) && scan_more;
    issue.pos      = idx_r[apt_pkg::SLOT_W-1:0];
    issue.slot     = rd_slot;
    issue.eligible = (op_r == apt_pkg::OP_PICK) && slot_mask_r[rd_slot][hart_r];
    issue.match    = (rd_slot == slot_r);
  end

  apt_age_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .rd_idx  (idx_r[apt_pkg::SLOT_W-1:0]),
    .rd_slot (rd_slot),
    .count   (age_cnt)
  );

  apt_weight_unit u_weight (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (accept),
    .issue (issue),
    .prio  (slot_prio_r[rd_slot]),
    .stamp (slot_stamp_r[rd_slot]),
    .tps   (tps_r),
    .now   (now_r),
    .res   (res)
  );

  // Queue update for the finished op
  always_comb begin
    q_ctrl = '0;
    q_ctrl.push_slot = slot_r;
    if (upd_go) begin
      case (op_r)
        apt_pkg::OP_INSERT: begin
          q_ctrl.drop_en  = slot_ready && res.match_hit;
          q_ctrl.drop_pos = res.match_pos;
          q_ctrl.push_en  = 1'b1;
        end
        apt_pkg::OP_REMOVE: begin
          q_ctrl.drop_en  = slot_ready && res.match_hit;
          q_ctrl.drop_pos = res.match_pos;
        end
        apt_pkg::OP_PICK: begin
          q_ctrl.drop_en  = res.hit;
          q_ctrl.drop_pos = res.best_pos;
        end
        default: ;
      endcase
    end
  end

  // Ready bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
    end else if (upd_go) begin
      case (op_r)
        apt_pkg::OP_INSERT: ready_r[slot_r] <= 1'b1;
        apt_pkg::OP_REMOVE: ready_r[slot_r] <= 1'b0;
        apt_pkg::OP_PICK:   if (res.hit) ready_r[res.best_slot] <= 1'b0;
        default:            ;
      endcase
    end
  end

  // Slot fields, written on insert
  always_ff @(posedge clk) begin
    if (upd_go && (op_r == apt_pkg::OP_INSERT)) begin
      slot_prio_r[slot_r]  <= prio_r;
      slot_mask_r[slot_r]  <= mask_r;
      slot_stamp_r[slot_r] <= now_r;
    end
  end

  // Result register: load on update, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      if ((op_r == apt_pkg::OP_PICK) && res.hit) begin
        out_found_r  <= 1'b1;
        out_winner_r <= res.best_slot;
        out_weight_r <= res.best_w;
      end else begin
        out_found_r  <= 1'b0;
        out_winner_r <= '0;
        out_weight_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_winner      = out_winner_r;
  assign out_best_weight = out_weight_r;

`ifndef ASSERT_OFF
  a_cnt_matches_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ready_r) == int'(age_cnt))
    else $error("age queue fill differs from ready bit count");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    age_cnt <= apt_pkg::CNT_W'(apt_pkg::SLOTS))
    else $error("age queue overfilled");

  a_found_weight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_best_weight != '0)
    else $error("pick returned a zero weight");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_winner == '0) && (out_best_weight == '0))
    else $error("empty result carries data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");
`endif

endmodule

@@ verif/apt_pick_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_pick_checker: result checker for the aging priority task picker
// Watches the config port and both item channels, keeps its own copy of the
// ready set, age order and ticks_per_second, predicts the result of every
// accepted item and compares each taken result, field by field, in order.
// ----------------------------------------------------------------------------
module apt_pick_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [apt_pkg::TPS_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [apt_pkg::OP_W-1:0]   in_op,
  input  logic [apt_pkg::SLOT_W-1:0] in_slot,
  input  logic [apt_pkg::PRIO_W-1:0] in_prio,
  input  logic [apt_pkg::HARTS-1:0]  in_eligible_harts,
  input  logic [apt_pkg::HART_W-1:0] in_hart,
  input  logic [apt_pkg::TIME_W-1:0] in_time_now,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_found,
  input  logic [apt_pkg::SLOT_W-1:0] out_winner,
  input  logic [apt_pkg::TIME_W-1:0] out_best_weight,
  output int                         fail_count,
  output int                         pending_count
);

  typedef struct packed {
    logic                       found;
    logic [apt_pkg::SLOT_W-1:0] winner;
    logic [apt_pkg::TIME_W-1:0] weight;
  } pick_result_t;

  logic [apt_pkg::TPS_W-1:0]  tps;
  logic [apt_pkg::SLOTS-1:0]  ready_set;
  logic [apt_pkg::PRIO_W-1:0] prio_of  [apt_pkg::SLOTS];
  logic [apt_pkg::HARTS-1:0]  mask_of  [apt_pkg::SLOTS];
  logic [apt_pkg::TIME_W-1:0] stamp_of [apt_pkg::SLOTS];
  logic [apt_pkg::SLOT_W-1:0] age_q [$];              // oldest slot first
  pick_result_t               expected_results [$];
  int                         fails = 0;

  // Scaled priority plus waiting time, wrapped to 32 bits
  function automatic logic [apt_pkg::TIME_W-1:0] aged_weight(
      logic [apt_pkg::SLOT_W-1:0] s, logic [apt_pkg::TIME_W-1:0] now);
    logic [apt_pkg::PROD_W-1:0] prod;
    prod = prio_of[s] * tps;
    return apt_pkg::TIME_W'(prod >> apt_pkg::WEIGHT_SHIFT) + now - stamp_of[s];
  endfunction

  function automatic void drop_from_age(logic [apt_pkg::SLOT_W-1:0] s);
    foreach (age_q[k]) begin
      if (age_q[k] == s) begin
        age_q.delete(k);
        return;
      end
    end
  endfunction

  // Update the ready set for one item and return the result it produces
  function automatic pick_result_t apply_item(apt_pkg::apt_op_t op,
                                              logic [apt_pkg::SLOT_W-1:0] slot,
                                              logic [apt_pkg::PRIO_W-1:0] prio,
                                              logic [apt_pkg::HARTS-1:0] mask,
                                              logic [apt_pkg::HART_W-1:0] hart,
                                              logic [apt_pkg::TIME_W-1:0] now);
    pick_result_t               res;
    int                         best_pos;
    logic [apt_pkg::TIME_W-1:0] best_w;
    logic [apt_pkg::TIME_W-1:0] w;
    logic [apt_pkg::SLOT_W-1:0] e;
    res = '0;
    case (op)
      apt_pkg::OP_INSERT: begin
        // refresh moves an existing entry to the newest place
        if (ready_set[slot]) drop_from_age(slot);
        prio_of[slot]  = prio;
        mask_of[slot]  = mask;
        stamp_of[slot] = now;
        ready_set[slot] = 1'b1;
        age_q.push_back(slot);
      end
      apt_pkg::OP_REMOVE: begin
        if (ready_set[slot]) begin
          drop_from_age(slot);
          ready_set[slot] = 1'b0;
        end
      end
      apt_pkg::OP_PICK: begin
        best_pos = -1;
        best_w   = '0;
        // strict compare keeps the oldest on a tie and rejects zero weight
        if (hart < apt_pkg::HARTS) begin
          foreach (age_q[k]) begin
            e = age_q[k];
            if (mask_of[e][hart]) begin
              w = aged_weight(e, now);
              if (w > best_w) begin
                best_w   = w;
                best_pos = k;
              end
            end
          end
        end
        if (best_pos >= 0) begin
          e = age_q[best_pos];
          age_q.delete(best_pos);
          ready_set[e] = 1'b0;
          res.found  = 1'b1;
          res.winner = e;
          res.weight = best_w;
        end
      end
      apt_pkg::OP_NOP: ;
    endcase
    return res;
  endfunction

  // Track config, predict accepted items, compare taken results
  always @(posedge clk) begin
    pick_result_t want;
    if (!rst_n) begin
      tps       = apt_pkg::TPS_RESET;
      ready_set = '0;
      age_q.delete();
      expected_results.delete();
    end else begin
      if (cfg_wr_en) tps = cfg_wr_data;
      if (in_valid && in_ready)
        expected_results.push_back(apply_item(apt_pkg::apt_op_t'(in_op), in_slot, in_prio,
                                              in_eligible_harts, in_hart, in_time_now));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: found %0d winner %0d weight %0d",
                   $time, out_found, out_winner, out_best_weight);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found mismatch: expected %0d, actual %0d",
                     $time, want.found, out_found);
            fails++;
          end
          if (out_winner !== want.winner) begin
            $display("%0t: winner mismatch: expected %0d, actual %0d",
                     $time, want.winner, out_winner);
            fails++;
          end
          if (out_best_weight !== want.weight) begin
            $display("%0t: best_weight mismatch: expected %0d, actual %0d",
                     $time, want.weight, out_best_weight);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    pending_count <= expected_results.size();
  end

endmodule

@@ verif/tb_aging_priority_task_picker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aging_priority_task_picker_top: testbench for the aging task picker
// Drives directed and random insert, remove, pick and no-op items through
// several ticks_per_second settings and idle patterns, including a long
// result hold-off, while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_aging_priority_task_picker_top;

  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 24;

  logic                       clk               = 1'b0;
  logic                       rst_n             = 1'b0;
  logic                       cfg_wr_en         = 1'b0;
  logic [apt_pkg::TPS_W-1:0]  cfg_wr_data       = '0;
  logic                       in_valid          = 1'b0;
  logic                       in_ready;
  logic [apt_pkg::OP_W-1:0]   in_op             = apt_pkg::OP_NOP;
  logic [apt_pkg::SLOT_W-1:0] in_slot           = '0;
  logic [apt_pkg::PRIO_W-1:0] in_prio           = '0;
  logic [apt_pkg::HARTS-1:0]  in_eligible_harts = '0;
  logic [apt_pkg::HART_W-1:0] in_hart           = '0;
  logic [apt_pkg::TIME_W-1:0] in_time_now       = '0;
  logic                       out_valid;
  logic                       out_ready         = 1'b0;
  logic                       out_found;
  logic [apt_pkg::SLOT_W-1:0] out_winner;
  logic [apt_pkg::TIME_W-1:0] out_best_weight;

  int                         fail_count;
  int                         pending_count;
  int                         send_idle_pct  = 0;
  int                         recv_stall_pct = 0;
  logic                       hold_toggle    = 1'b0;
  logic                       hold_seen      = 1'b0;
  int                         hold_left      = 0;
  logic [apt_pkg::TIME_W-1:0] clock_now      = '0;

  always #5 clk = ~clk;

  aging_priority_task_picker_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_slot           (in_slot),
    .in_prio           (in_prio),
    .in_eligible_harts (in_eligible_harts),
    .in_hart           (in_hart),
    .in_time_now       (in_time_now),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_winner        (out_winner),
    .out_best_weight   (out_best_weight)
  );

  apt_pick_checker pick_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_slot           (in_slot),
    .in_prio           (in_prio),
    .in_eligible_harts (in_eligible_harts),
    .in_hart           (in_hart),
    .in_time_now       (in_time_now),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_winner        (out_winner),
    .out_best_weight   (out_best_weight),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  // Drive result ready: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item, idling first at random; return at the accepting edge
  task automatic send_item(apt_pkg::apt_op_t op, logic [apt_pkg::SLOT_W-1:0] slot,
                           logic [apt_pkg::PRIO_W-1:0] prio,
                           logic [apt_pkg::HARTS-1:0] mask,
                           logic [apt_pkg::HART_W-1:0] hart,
                           logic [apt_pkg::TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_slot           <= slot;
    in_prio           <= prio;
    in_eligible_harts <= mask;
    in_hart           <= hart;
    in_time_now       <= now;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Random item: mostly a running clock, now and then any time at all
  task automatic send_random_item(int insert_pct);
    int                         roll;
    apt_pkg::apt_op_t           op;
    logic [apt_pkg::TIME_W-1:0] now;
    roll = $urandom_range(99);
    if (roll < insert_pct) op = apt_pkg::OP_INSERT;
    else if (roll < insert_pct + (100 - insert_pct) / 2) op = apt_pkg::OP_PICK;
    else if (roll < 93) op = apt_pkg::OP_REMOVE;
    else op = apt_pkg::OP_NOP;
    if ($urandom_range(3) != 0)
      clock_now += $urandom_range(1 << $urandom_range(16));
    now = ($urandom_range(15) == 0) ? $urandom() : clock_now;
    send_item(op, apt_pkg::SLOT_W'($urandom_range(15)),
              apt_pkg::PRIO_W'($urandom_range(15)),
              apt_pkg::HARTS'($urandom_range(3)),
              apt_pkg::HART_W'($urandom_range(1)), now);
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_tps(logic [apt_pkg::TPS_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pick, ignored remove, no-op at field extremes
    send_item(apt_pkg::OP_PICK,   0, 0, 0, 0, 32'd0);
    send_item(apt_pkg::OP_REMOVE, 5, 0, 0, 0, 32'd0);
    send_item(apt_pkg::OP_NOP,    15, 15, 3, 1, 32'hFFFF_FFFF);
    // zero weight is never picked, and the entry stays ready
    send_item(apt_pkg::OP_INSERT, 0, 0, 3, 0, 32'd100);
    send_item(apt_pkg::OP_PICK,   0, 0, 0, 0, 32'd100);
    send_item(apt_pkg::OP_REMOVE, 0, 0, 0, 0, 32'd0);
    // priority above 9, eligible on hart 1 only
    send_item(apt_pkg::OP_INSERT, 15, 15, 2, 0, 32'hFFFF_FFFF);
    send_item(apt_pkg::OP_PICK,   0, 0, 0, 0, 32'd0);
    // equal weights: oldest wins; a refresh makes an entry the newest
    send_item(apt_pkg::OP_INSERT, 3, 5, 1, 0, 32'd50);
    send_item(apt_pkg::OP_INSERT, 7, 5, 3, 0, 32'd50);
    send_item(apt_pkg::OP_PICK,   0, 0, 0, 0, 32'd60);
    send_item(apt_pkg::OP_INSERT, 3, 5, 1, 0, 32'd50);
    send_item(apt_pkg::OP_INSERT, 7, 5, 3, 0, 32'd50);
    send_item(apt_pkg::OP_PICK,   0, 0, 0, 0, 32'd60);
    send_item(apt_pkg::OP_PICK,   0, 0, 0, 1, 32'd0);
    send_item(apt_pkg::OP_PICK,   0, 0, 0, 0, 32'd0);
    // waiting time across the 32-bit wrap of the clock
    send_item(apt_pkg::OP_INSERT, 9, 9, 3, 1, 32'hFFFF_FFF0);
    send_item(apt_pkg::OP_PICK,   0, 0, 0, 1, 32'd10);
    send_item(apt_pkg::OP_REMOVE, 9, 0, 0, 0, 32'd0);

    // Random phases over idle patterns and ticks_per_second settings
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      case (p)
        1: write_tps('0);
        2: write_tps('1);
        3: write_tps(apt_pkg::TPS_W'($urandom_range(16777215)));
        4: write_tps(24'd1);
        5: write_tps(apt_pkg::TPS_W'($urandom_range(16777215)));
        default: ;
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold results off while items keep coming, so the input stalls
        if (p == 4 && n == 60) hold_toggle <= ~hold_toggle;
        // alternate insert-heavy stretches to fill the ready set
        send_random_item(((n / 40) % 2 == 0) ? 70 : 35);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
